// File: rtl/dfq_pkg.sv
package dfq_pkg;

   localparam int DEPTH   = 16;
   localparam int KEY_W   = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_SIZE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_DUP   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // per-cell control from the queue controller
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// File: rtl/dfq_cell.sv
module dfq_cell
   import dfq_pkg::*;
(
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic signed [KEY_W-1:0] in_key,
   input  logic signed [KEY_W-1:0] next_key,
   output logic signed [KEY_W-1:0] key_out,
   output logic                    match
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;

   // load a new key, take the neighbor's key on a pop, or hold
   always_comb begin
      if (ctrl.load) begin
         key_in = in_key;
      end else if (ctrl.shift) begin
         key_in = next_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;
   assign match   = (key_ff == in_key);

endmodule

// File: rtl/dedup_fifo_queue.sv
// Deduplicating FIFO of signed 32-bit keys, DEPTH entries held in a row of
// cells with the oldest key in cell 0. A request is taken when start is high
// and busy is low; busy then stays high for one cycle while every cell
// compares its key with the request key at once, and the result appears on
// the rsp_ ports for exactly one cycle, marked by rsp_valid. The receiver
// cannot stall, so it must take the result in that cycle. The request is
// registered, and no new request is taken until the compare and update of
// the last one is done. A pop moves every key one cell toward the head in
// the compare-and-update cycle. Insert answers duplicate before full.
module dedup_fifo_queue
   import dfq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_cmd,
   input  logic signed [KEY_W-1:0]   req_key,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic signed [KEY_W-1:0]   rsp_removed_key,
   output logic                      rsp_found,
   output logic [ENTRY_W-1:0]        rsp_entry_count
);

   logic                      busy_ff;
   cmd_type                   cmd_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   logic                      rsp_valid_ff;
   status_type                status_ff;
   status_type                status_in;
   logic signed [KEY_W-1:0]   removed_ff;
   logic signed [KEY_W-1:0]   removed_in;
   logic                      found_ff;
   logic                      found_in;
   logic [ENTRY_W-1:0]        entry_ff;

   logic signed [KEY_W-1:0]   cell_key [DEPTH];
   logic [DEPTH-1:0]          match_vec;
   logic [DEPTH-1:0]          occ_vec;
   cell_ctrl_type             ctrl_vec [DEPTH];

   logic                      hit;
   logic                      do_load;
   logic                      do_shift;
   logic                      accept;

   assign accept = start && !busy_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [KEY_W-1:0] nbr_key;

      if (i == DEPTH - 1) begin : g_last
         assign nbr_key = '0;
      end else begin : g_mid
         assign nbr_key = cell_key[i+1];
      end

      assign occ_vec[i]        = (CNT_W'(i) < count_ff);
      assign ctrl_vec[i].shift = do_shift;
      assign ctrl_vec[i].load  = do_load && (count_ff == CNT_W'(i));

      dfq_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl_vec[i]),
         .in_key   (key_ff),
         .next_key (nbr_key),
         .key_out  (cell_key[i]),
         .match    (match_vec[i])
      );
   end

   assign hit = |(match_vec & occ_vec);

   always_comb begin
      do_load    = 1'b0;
      do_shift   = 1'b0;
      count_in   = count_ff;
      status_in  = ST_DONE;
      removed_in = '0;
      found_in   = 1'b0;
      if (busy_ff) begin
         case (cmd_ff)
            CMD_INSERT: begin
               if (hit) begin
                  status_in = ST_DUP;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  do_load  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  do_shift   = 1'b1;
                  removed_in = cell_key[0];
                  count_in   = count_ff - 1'b1;
               end
            end
            CMD_SEARCH: begin
               found_in = hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= busy_ff;
         count_ff     <= count_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         key_ff <= req_key;
      end
      if (busy_ff) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         found_ff   <= found_in;
         entry_ff   <= ENTRY_W'(count_in);
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_removed_key = removed_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_count = entry_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("request accepted without going busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> (rsp_valid_ff && !busy_ff))
      else $error("result missing after compare cycle");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && rsp_valid_ff))
      else $error("busy and result strobe together");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && status_in != ST_DONE) |=> (count_ff == $past(count_ff)))
      else $error("rejected command changed the entry count");

endmodule
